// ----- design/bf_pkg.sv -----
// Shared constants, codes and pi-digit initial tables for the block cipher engine.
package bf_pkg;

    // Function codes on the request channel
    localparam logic [1:0] FUNC_ENC = 2'd0;
    localparam logic [1:0] FUNC_DEC = 2'd1;
    localparam logic [1:0] FUNC_KEY = 2'd2;

    // Result kinds
    localparam logic KIND_BLOCK = 1'b0;
    localparam logic KIND_DONE  = 1'b1;

    localparam int ROUNDS                = 16;
    localparam int NUM_SUBKEYS           = ROUNDS + 2;
    localparam int SBOX_DEPTH            = 256;
    localparam int NUM_SBOXES            = 4;
    localparam int EXP_PAIRS             = (NUM_SUBKEYS + NUM_SBOXES * SBOX_DEPTH) / 2;
    localparam int P_PAIRS               = NUM_SUBKEYS / 2;
    localparam int DEFAULT_MAX_KEY_BYTES = 56;

    // Initial subkeys
    localparam logic [31:0] P_INIT [NUM_SUBKEYS] = '{
        32'h243F6A88, 32'h85A308D3, 32'h13198A2E, 32'h03707344,
        32'hA4093822, 32'h299F31D0, 32'h082EFA98, 32'hEC4E6C89,
        32'h452821E6, 32'h38D01377, 32'hBE5466CF, 32'h34E90C6C,
        32'hC0AC29B7, 32'hC97C50DD, 32'h3F84D5B5, 32'hB5470917,
        32'h9216D5D9, 32'h8979FB1B
    };

    // Initial substitution boxes, box b entry e at b*256+e
    localparam logic [31:0] SBOX_INIT [NUM_SBOXES * SBOX_DEPTH] = '{
        32'hD1310BA6, 32'h98DFB5AC, 32'h2FFD72DB, 32'hD01ADFB7,
        32'hB8E1AFED, 32'h6A267E96, 32'hBA7C9045, 32'hF12C7F99,
        32'h24A19947, 32'hB3916CF7, 32'h0801F2E2, 32'h858EFC16,
        32'h636920D8, 32'h71574E69, 32'hA458FEA3, 32'hF4933D7E,
        32'h0D95748F, 32'h728EB658, 32'h718BCD58, 32'h82154AEE,
        32'h7B54A41D, 32'hC25A59B5, 32'h9C30D539, 32'h2AF26013,
        32'hC5D1B023, 32'h286085F0, 32'hCA417918, 32'hB8DB38EF,
        32'h8E79DCB0, 32'h603A180E, 32'h6C9E0E8B, 32'hB01E8A3E,
        32'hD71577C1, 32'hBD314B27, 32'h78AF2FDA, 32'h55605C60,
        32'hE65525F3, 32'hAA55AB94, 32'h57489862, 32'h63E81440,
        32'h55CA396A, 32'h2AAB10B6, 32'hB4CC5C34, 32'h1141E8CE,
        32'hA15486AF, 32'h7C72E993, 32'hB3EE1411, 32'h636FBC2A,
        32'h2BA9C55D, 32'h741831F6, 32'hCE5C3E16, 32'h9B87931E,
        32'hAFD6BA33, 32'h6C24CF5C, 32'h7A325381, 32'h28958677,
        32'h3B8F4898, 32'h6B4BB9AF, 32'hC4BFE81B, 32'h66282193,
        32'h61D809CC, 32'hFB21A991, 32'h487CAC60, 32'h5DEC8032,
        32'hEF845D5D, 32'hE98575B1, 32'hDC262302, 32'hEB651B88,
        32'h23893E81, 32'hD396ACC5, 32'h0F6D6FF3, 32'h83F44239,
        32'h2E0B4482, 32'hA4842004, 32'h69C8F04A, 32'h9E1F9B5E,
        32'h21C66842, 32'hF6E96C9A, 32'h670C9C61, 32'hABD388F0,
        32'h6A51A0D2, 32'hD8542F68, 32'h960FA728, 32'hAB5133A3,
        32'h6EEF0B6C, 32'h137A3BE4, 32'hBA3BF050, 32'h7EFB2A98,
        32'hA1F1651D, 32'h39AF0176, 32'h66CA593E, 32'h82430E88,
        32'h8CEE8619, 32'h456F9FB4, 32'h7D84A5C3, 32'h3B8B5EBE,
        32'hE06F75D8, 32'h85C12073, 32'h401A449F, 32'h56C16AA6,
        32'h4ED3AA62, 32'h363F7706, 32'h1BFEDF72, 32'h429B023D,
        32'h37D0D724, 32'hD00A1248, 32'hDB0FEAD3, 32'h49F1C09B,
        32'h075372C9, 32'h80991B7B, 32'h25D479D8, 32'hF6E8DEF7,
        32'hE3FE501A, 32'hB6794C3B, 32'h976CE0BD, 32'h04C006BA,
        32'hC1A94FB6, 32'h409F60C4, 32'h5E5C9EC2, 32'h196A2463,
        32'h68FB6FAF, 32'h3E6C53B5, 32'h1339B2EB, 32'h3B52EC6F,
        32'h6DFC511F, 32'h9B30952C, 32'hCC814544, 32'hAF5EBD09,
        32'hBEE3D004, 32'hDE334AFD, 32'h660F2807, 32'h192E4BB3,
        32'hC0CBA857, 32'h45C8740F, 32'hD20B5F39, 32'hB9D3FBDB,
        32'h5579C0BD, 32'h1A60320A, 32'hD6A100C6, 32'h402C7279,
        32'h679F25FE, 32'hFB1FA3CC, 32'h8EA5E9F8, 32'hDB3222F8,
        32'h3C7516DF, 32'hFD616B15, 32'h2F501EC8, 32'hAD0552AB,
        32'h323DB5FA, 32'hFD238760, 32'h53317B48, 32'h3E00DF82,
        32'h9E5C57BB, 32'hCA6F8CA0, 32'h1A87562E, 32'hDF1769DB,
        32'hD542A8F6, 32'h287EFFC3, 32'hAC6732C6, 32'h8C4F5573,
        32'h695B27B0, 32'hBBCA58C8, 32'hE1FFA35D, 32'hB8F011A0,
        32'h10FA3D98, 32'hFD2183B8, 32'h4AFCB56C, 32'h2DD1D35B,
        32'h9A53E479, 32'hB6F84565, 32'hD28E49BC, 32'h4BFB9790,
        32'hE1DDF2DA, 32'hA4CB7E33, 32'h62FB1341, 32'hCEE4C6E8,
        32'hEF20CADA, 32'h36774C01, 32'hD07E9EFE, 32'h2BF11FB4,
        32'h95DBDA4D, 32'hAE909198, 32'hEAAD8E71, 32'h6B93D5A0,
        32'hD08ED1D0, 32'hAFC725E0, 32'h8E3C5B2F, 32'h8E7594B7,
        32'h8FF6E2FB, 32'hF2122B64, 32'h8888B812, 32'h900DF01C,
        32'h4FAD5EA0, 32'h688FC31C, 32'hD1CFF191, 32'hB3A8C1AD,
        32'h2F2F2218, 32'hBE0E1777, 32'hEA752DFE, 32'h8B021FA1,
        32'hE5A0CC0F, 32'hB56F74E8, 32'h18ACF3D6, 32'hCE89E299,
        32'hB4A84FE0, 32'hFD13E0B7, 32'h7CC43B81, 32'hD2ADA8D9,
        32'h165FA266, 32'h80957705, 32'h93CC7314, 32'h211A1477,
        32'hE6AD2065, 32'h77B5FA86, 32'hC75442F5, 32'hFB9D35CF,
        32'hEBCDAF0C, 32'h7B3E89A0, 32'hD6411BD3, 32'hAE1E7E49,
        32'h00250E2D, 32'h2071B35E, 32'h226800BB, 32'h57B8E0AF,
        32'h2464369B, 32'hF009B91E, 32'h5563911D, 32'h59DFA6AA,
        32'h78C14389, 32'hD95A537F, 32'h207D5BA2, 32'h02E5B9C5,
        32'h83260376, 32'h6295CFA9, 32'h11C81968, 32'h4E734A41,
        32'hB3472DCA, 32'h7B14A94A, 32'h1B510052, 32'h9A532915,
        32'hD60F573F, 32'hBC9BC6E4, 32'h2B60A476, 32'h81E67400,
        32'h08BA6FB5, 32'h571BE91F, 32'hF296EC6B, 32'h2A0DD915,
        32'hB6636521, 32'hE7B9F9B6, 32'hFF34052E, 32'hC5855664,
        32'h53B02D5D, 32'hA99F8FA1, 32'h08BA4799, 32'h6E85076A,
        32'h4B7A70E9, 32'hB5B32944, 32'hDB75092E, 32'hC4192623,
        32'hAD6EA6B0, 32'h49A7DF7D, 32'h9CEE60B8, 32'h8FEDB266,
        32'hECAA8C71, 32'h699A17FF, 32'h5664526C, 32'hC2B19EE1,
        32'h193602A5, 32'h75094C29, 32'hA0591340, 32'hE4183A3E,
        32'h3F54989A, 32'h5B429D65, 32'h6B8FE4D6, 32'h99F73FD6,
        32'hA1D29C07, 32'hEFE830F5, 32'h4D2D38E6, 32'hF0255DC1,
        32'h4CDD2086, 32'h8470EB26, 32'h6382E9C6, 32'h021ECC5E,
        32'h09686B3F, 32'h3EBAEFC9, 32'h3C971814, 32'h6B6A70A1,
        32'h687F3584, 32'h52A0E286, 32'hB79C5305, 32'hAA500737,
        32'h3E07841C, 32'h7FDEAE5C, 32'h8E7D44EC, 32'h5716F2B8,
        32'hB03ADA37, 32'hF0500C0D, 32'hF01C1F04, 32'h0200B3FF,
        32'hAE0CF51A, 32'h3CB574B2, 32'h25837A58, 32'hDC0921BD,
        32'hD19113F9, 32'h7CA92FF6, 32'h94324773, 32'h22F54701,
        32'h3AE5E581, 32'h37C2DADC, 32'hC8B57634, 32'h9AF3DDA7,
        32'hA9446146, 32'h0FD0030E, 32'hECC8C73E, 32'hA4751E41,
        32'hE238CD99, 32'h3BEA0E2F, 32'h3280BBA1, 32'h183EB331,
        32'h4E548B38, 32'h4F6DB908, 32'h6F420D03, 32'hF60A04BF,
        32'h2CB81290, 32'h24977C79, 32'h5679B072, 32'hBCAF89AF,
        32'hDE9A771F, 32'hD9930810, 32'hB38BAE12, 32'hDCCF3F2E,
        32'h5512721F, 32'h2E6B7124, 32'h501ADDE6, 32'h9F84CD87,
        32'h7A584718, 32'h7408DA17, 32'hBC9F9ABC, 32'hE94B7D8C,
        32'hEC7AEC3A, 32'hDB851DFA, 32'h63094366, 32'hC464C3D2,
        32'hEF1C1847, 32'h3215D908, 32'hDD433B37, 32'h24C2BA16,
        32'h12A14D43, 32'h2A65C451, 32'h50940002, 32'h133AE4DD,
        32'h71DFF89E, 32'h10314E55, 32'h81AC77D6, 32'h5F11199B,
        32'h043556F1, 32'hD7A3C76B, 32'h3C11183B, 32'h5924A509,
        32'hF28FE6ED, 32'h97F1FBFA, 32'h9EBABF2C, 32'h1E153C6E,
        32'h86E34570, 32'hEAE96FB1, 32'h860E5E0A, 32'h5A3E2AB3,
        32'h771FE71C, 32'h4E3D06FA, 32'h2965DCB9, 32'h99E71D0F,
        32'h803E89D6, 32'h5266C825, 32'h2E4CC978, 32'h9C10B36A,
        32'hC6150EBA, 32'h94E2EA78, 32'hA5FC3C53, 32'h1E0A2DF4,
        32'hF2F74EA7, 32'h361D2B3D, 32'h1939260F, 32'h19C27960,
        32'h5223A708, 32'hF71312B6, 32'hEBADFE6E, 32'hEAC31F66,
        32'hE3BC4595, 32'hA67BC883, 32'hB17F37D1, 32'h018CFF28,
        32'hC332DDEF, 32'hBE6C5AA5, 32'h65582185, 32'h68AB9802,
        32'hEECEA50F, 32'hDB2F953B, 32'h2AEF7DAD, 32'h5B6E2F84,
        32'h1521B628, 32'h29076170, 32'hECDD4775, 32'h619F1510,
        32'h13CCA830, 32'hEB61BD96, 32'h0334FE1E, 32'hAA0363CF,
        32'hB5735C90, 32'h4C70A239, 32'hD59E9E0B, 32'hCBAADE14,
        32'hEECC86BC, 32'h60622CA7, 32'h9CAB5CAB, 32'hB2F3846E,
        32'h648B1EAF, 32'h19BDF0CA, 32'hA02369B9, 32'h655ABB50,
        32'h40685A32, 32'h3C2AB4B3, 32'h319EE9D5, 32'hC021B8F7,
        32'h9B540B19, 32'h875FA099, 32'h95F7997E, 32'h623D7DA8,
        32'hF837889A, 32'h97E32D77, 32'h11ED935F, 32'h16681281,
        32'h0E358829, 32'hC7E61FD6, 32'h96DEDFA1, 32'h7858BA99,
        32'h57F584A5, 32'h1B227263, 32'h9B83C3FF, 32'h1AC24696,
        32'hCDB30AEB, 32'h532E3054, 32'h8FD948E4, 32'h6DBC3128,
        32'h58EBF2EF, 32'h34C6FFEA, 32'hFE28ED61, 32'hEE7C3C73,
        32'h5D4A14D9, 32'hE864B7E3, 32'h42105D14, 32'h203E13E0,
        32'h45EEE2B6, 32'hA3AAABEA, 32'hDB6C4F15, 32'hFACB4FD0,
        32'hC742F442, 32'hEF6ABBB5, 32'h654F3B1D, 32'h41CD2105,
        32'hD81E799E, 32'h86854DC7, 32'hE44B476A, 32'h3D816250,
        32'hCF62A1F2, 32'h5B8D2646, 32'hFC8883A0, 32'hC1C7B6A3,
        32'h7F1524C3, 32'h69CB7492, 32'h47848A0B, 32'h5692B285,
        32'h095BBF00, 32'hAD19489D, 32'h1462B174, 32'h23820E00,
        32'h58428D2A, 32'h0C55F5EA, 32'h1DADF43E, 32'h233F7061,
        32'h3372F092, 32'h8D937E41, 32'hD65FECF1, 32'h6C223BDB,
        32'h7CDE3759, 32'hCBEE7460, 32'h4085F2A7, 32'hCE77326E,
        32'hA6078084, 32'h19F8509E, 32'hE8EFD855, 32'h61D99735,
        32'hA969A7AA, 32'hC50C06C2, 32'h5A04ABFC, 32'h800BCADC,
        32'h9E447A2E, 32'hC3453484, 32'hFDD56705, 32'h0E1E9EC9,
        32'hDB73DBD3, 32'h105588CD, 32'h675FDA79, 32'hE3674340,
        32'hC5C43465, 32'h713E38D8, 32'h3D28F89E, 32'hF16DFF20,
        32'h153E21E7, 32'h8FB03D4A, 32'hE6E39F2B, 32'hDB83ADF7,
        32'hE93D5A68, 32'h948140F7, 32'hF64C261C, 32'h94692934,
        32'h411520F7, 32'h7602D4F7, 32'hBCF46B2E, 32'hD4A20068,
        32'hD4082471, 32'h3320F46A, 32'h43B7D4B7, 32'h500061AF,
        32'h1E39F62E, 32'h97244546, 32'h14214F74, 32'hBF8B8840,
        32'h4D95FC1D, 32'h96B591AF, 32'h70F4DDD3, 32'h66A02F45,
        32'hBFBC09EC, 32'h03BD9785, 32'h7FAC6DD0, 32'h31CB8504,
        32'h96EB27B3, 32'h55FD3941, 32'hDA2547E6, 32'hABCA0A9A,
        32'h28507825, 32'h530429F4, 32'h0A2C86DA, 32'hE9B66DFB,
        32'h68DC1462, 32'hD7486900, 32'h680EC0A4, 32'h27A18DEE,
        32'h4F3FFEA2, 32'hE887AD8C, 32'hB58CE006, 32'h7AF4D6B6,
        32'hAACE1E7C, 32'hD3375FEC, 32'hCE78A399, 32'h406B2A42,
        32'h20FE9E35, 32'hD9F385B9, 32'hEE39D7AB, 32'h3B124E8B,
        32'h1DC9FAF7, 32'h4B6D1856, 32'h26A36631, 32'hEAE397B2,
        32'h3A6EFA74, 32'hDD5B4332, 32'h6841E7F7, 32'hCA7820FB,
        32'hFB0AF54E, 32'hD8FEB397, 32'h454056AC, 32'hBA489527,
        32'h55533A3A, 32'h20838D87, 32'hFE6BA9B7, 32'hD096954B,
        32'h55A867BC, 32'hA1159A58, 32'hCCA92963, 32'h99E1DB33,
        32'hA62A4A56, 32'h3F3125F9, 32'h5EF47E1C, 32'h9029317C,
        32'hFDF8E802, 32'h04272F70, 32'h80BB155C, 32'h05282CE3,
        32'h95C11548, 32'hE4C66D22, 32'h48C1133F, 32'hC70F86DC,
        32'h07F9C9EE, 32'h41041F0F, 32'h404779A4, 32'h5D886E17,
        32'h325F51EB, 32'hD59BC0D1, 32'hF2BCC18F, 32'h41113564,
        32'h257B7834, 32'h602A9C60, 32'hDFF8E8A3, 32'h1F636C1B,
        32'h0E12B4C2, 32'h02E1329E, 32'hAF664FD1, 32'hCAD18115,
        32'h6B2395E0, 32'h333E92E1, 32'h3B240B62, 32'hEEBEB922,
        32'h85B2A20E, 32'hE6BA0D99, 32'hDE720C8C, 32'h2DA2F728,
        32'hD0127845, 32'h95B794FD, 32'h647D0862, 32'hE7CCF5F0,
        32'h5449A36F, 32'h877D48FA, 32'hC39DFD27, 32'hF33E8D1E,
        32'h0A476341, 32'h992EFF74, 32'h3A6F6EAB, 32'hF4F8FD37,
        32'hA812DC60, 32'hA1EBDDF8, 32'h991BE14C, 32'hDB6E6B0D,
        32'hC67B5510, 32'h6D672C37, 32'h2765D43B, 32'hDCD0E804,
        32'hF1290DC7, 32'hCC00FFA3, 32'hB5390F92, 32'h690FED0B,
        32'h667B9FFB, 32'hCEDB7D9C, 32'hA091CF0B, 32'hD9155EA3,
        32'hBB132F88, 32'h515BAD24, 32'h7B9479BF, 32'h763BD6EB,
        32'h37392EB3, 32'hCC115979, 32'h8026E297, 32'hF42E312D,
        32'h6842ADA7, 32'hC66A2B3B, 32'h12754CCC, 32'h782EF11C,
        32'h6A124237, 32'hB79251E7, 32'h06A1BBE6, 32'h4BFB6350,
        32'h1A6B1018, 32'h11CAEDFA, 32'h3D25BDD8, 32'hE2E1C3C9,
        32'h44421659, 32'h0A121386, 32'hD90CEC6E, 32'hD5ABEA2A,
        32'h64AF674E, 32'hDA86A85F, 32'hBEBFE988, 32'h64E4C3FE,
        32'h9DBC8057, 32'hF0F7C086, 32'h60787BF8, 32'h6003604D,
        32'hD1FD8346, 32'hF6381FB0, 32'h7745AE04, 32'hD736FCCC,
        32'h83426B33, 32'hF01EAB71, 32'hB0804187, 32'h3C005E5F,
        32'h77A057BE, 32'hBDE8AE24, 32'h55464299, 32'hBF582E61,
        32'h4E58F48F, 32'hF2DDFDA2, 32'hF474EF38, 32'h8789BDC2,
        32'h5366F9C3, 32'hC8B38E74, 32'hB475F255, 32'h46FCD9B9,
        32'h7AEB2661, 32'h8B1DDF84, 32'h846A0E79, 32'h915F95E2,
        32'h466E598E, 32'h20B45770, 32'h8CD55591, 32'hC902DE4C,
        32'hB90BACE1, 32'hBB8205D0, 32'h11A86248, 32'h7574A99E,
        32'hB77F19B6, 32'hE0A9DC09, 32'h662D09A1, 32'hC4324633,
        32'hE85A1F02, 32'h09F0BE8C, 32'h4A99A025, 32'h1D6EFE10,
        32'h1AB93D1D, 32'h0BA5A4DF, 32'hA186F20F, 32'h2868F169,
        32'hDCB7DA83, 32'h573906FE, 32'hA1E2CE9B, 32'h4FCD7F52,
        32'h50115E01, 32'hA70683FA, 32'hA002B5C4, 32'h0DE6D027,
        32'h9AF88C27, 32'h773F8641, 32'hC3604C06, 32'h61A806B5,
        32'hF0177A28, 32'hC0F586E0, 32'h006058AA, 32'h30DC7D62,
        32'h11E69ED7, 32'h2338EA63, 32'h53C2DD94, 32'hC2C21634,
        32'hBBCBEE56, 32'h90BCB6DE, 32'hEBFC7DA1, 32'hCE591D76,
        32'h6F05E409, 32'h4B7C0188, 32'h39720A3D, 32'h7C927C24,
        32'h86E3725F, 32'h724D9DB9, 32'h1AC15BB4, 32'hD39EB8FC,
        32'hED545578, 32'h08FCA5B5, 32'hD83D7CD3, 32'h4DAD0FC4,
        32'h1E50EF5E, 32'hB161E6F8, 32'hA28514D9, 32'h6C51133C,
        32'h6FD5C7E7, 32'h56E14EC4, 32'h362ABFCE, 32'hDDC6C837,
        32'hD79A3234, 32'h92638212, 32'h670EFA8E, 32'h406000E0,
        32'h3A39CE37, 32'hD3FAF5CF, 32'hABC27737, 32'h5AC52D1B,
        32'h5CB0679E, 32'h4FA33742, 32'hD3822740, 32'h99BC9BBE,
        32'hD5118E9D, 32'hBF0F7315, 32'hD62D1C7E, 32'hC700C47B,
        32'hB78C1B6B, 32'h21A19045, 32'hB26EB1BE, 32'h6A366EB4,
        32'h5748AB2F, 32'hBC946E79, 32'hC6A376D2, 32'h6549C2C8,
        32'h530FF8EE, 32'h468DDE7D, 32'hD5730A1D, 32'h4CD04DC6,
        32'h2939BBDB, 32'hA9BA4650, 32'hAC9526E8, 32'hBE5EE304,
        32'hA1FAD5F0, 32'h6A2D519A, 32'h63EF8CE2, 32'h9A86EE22,
        32'hC089C2B8, 32'h43242EF6, 32'hA51E03AA, 32'h9CF2D0A4,
        32'h83C061BA, 32'h9BE96A4D, 32'h8FE51550, 32'hBA645BD6,
        32'h2826A2F9, 32'hA73A3AE1, 32'h4BA99586, 32'hEF5562E9,
        32'hC72FEFD3, 32'hF752F7DA, 32'h3F046F69, 32'h77FA0A59,
        32'h80E4A915, 32'h87B08601, 32'h9B09E6AD, 32'h3B3EE593,
        32'hE990FD5A, 32'h9E34D797, 32'h2CF0B7D9, 32'h022B8B51,
        32'h96D5AC3A, 32'h017DA67D, 32'hD1CF3ED6, 32'h7C7D2D28,
        32'h1F9F25CF, 32'hADF2B89B, 32'h5AD6B472, 32'h5A88F54C,
        32'hE029AC71, 32'hE019A5E6, 32'h47B0ACFD, 32'hED93FA9B,
        32'hE8D3C48D, 32'h283B57CC, 32'hF8D56629, 32'h79132E28,
        32'h785F0191, 32'hED756055, 32'hF7960E44, 32'hE3D35E8C,
        32'h15056DD4, 32'h88F46DBA, 32'h03A16125, 32'h0564F0BD,
        32'hC3EB9E15, 32'h3C9057A2, 32'h97271AEC, 32'hA93A072A,
        32'h1B3F6D9B, 32'h1E6321F5, 32'hF59C66FB, 32'h26DCF319,
        32'h7533D928, 32'hB155FDF5, 32'h03563482, 32'h8ABA3CBB,
        32'h28517711, 32'hC20AD9F8, 32'hABCC5167, 32'hCCAD925F,
        32'h4DE81751, 32'h3830DC8E, 32'h379D5862, 32'h9320F991,
        32'hEA7A90C2, 32'hFB3E7BCE, 32'h5121CE64, 32'h774FBE32,
        32'hA8B6E37E, 32'hC3293D46, 32'h48DE5369, 32'h6413E680,
        32'hA2AE0810, 32'hDD6DB224, 32'h69852DFD, 32'h09072166,
        32'hB39A460A, 32'h6445C0DD, 32'h586CDECF, 32'h1C20C8AE,
        32'h5BBEF7DD, 32'h1B588D40, 32'hCCD2017F, 32'h6BB4E3BB,
        32'hDDA26A7E, 32'h3A59FF45, 32'h3E350A44, 32'hBCB4CDD5,
        32'h72EACEA8, 32'hFA6484BB, 32'h8D6612AE, 32'hBF3C6F47,
        32'hD29BE463, 32'h542F5D9E, 32'hAEC2771B, 32'hF64E6370,
        32'h740E0D8D, 32'hE75B1357, 32'hF8721671, 32'hAF537D5D,
        32'h4040CB08, 32'h4EB4E2CC, 32'h34D2466A, 32'h0115AF84,
        32'hE1B00428, 32'h95983A1D, 32'h06B89FB4, 32'hCE6EA048,
        32'h6F3F3B82, 32'h3520AB82, 32'h011A1D4B, 32'h277227F8,
        32'h611560B1, 32'hE7933FDC, 32'hBB3A792B, 32'h344525BD,
        32'hA08839E1, 32'h51CE794B, 32'h2F32C9B7, 32'hA01FBAC9,
        32'hE01CC87E, 32'hBCC7D1F6, 32'hCF0111C3, 32'hA1E8AAC7,
        32'h1A908749, 32'hD44FBD9A, 32'hD0DADECB, 32'hD50ADA38,
        32'h0339C32A, 32'hC6913667, 32'h8DF9317C, 32'hE0B12B4F,
        32'hF79E59B7, 32'h43F5BB3A, 32'hF2D519FF, 32'h27D9459C,
        32'hBF97222C, 32'h15E6FC2A, 32'h0F91FC71, 32'h9B941525,
        32'hFAE59361, 32'hCEB69CEB, 32'hC2A86459, 32'h12BAA8D1,
        32'hB6C1075E, 32'hE3056A0C, 32'h10D25065, 32'hCB03A442,
        32'hE0EC6E0E, 32'h1698DB3B, 32'h4C98A0BE, 32'h3278E964,
        32'h9F1F9532, 32'hE0D392DF, 32'hD3A0342B, 32'h8971F21E,
        32'h1B0A7441, 32'h4BA3348C, 32'hC5BE7120, 32'hC37632D8,
        32'hDF359F8D, 32'h9B992F2E, 32'hE60B6F47, 32'h0FE3F11D,
        32'hE54CDA54, 32'h1EDAD891, 32'hCE6279CF, 32'hCD3E7E6F,
        32'h1618B166, 32'hFD2C1D05, 32'h848FD2C5, 32'hF6FB2299,
        32'hF523F357, 32'hA6327623, 32'h93A83531, 32'h56CCCD02,
        32'hACF08162, 32'h5A75EBB5, 32'h6E163697, 32'h88D273CC,
        32'hDE966292, 32'h81B949D0, 32'h4C50901B, 32'h71C65614,
        32'hE6C6C7BD, 32'h327A140A, 32'h45E1D006, 32'hC3F27B9A,
        32'hC9AA53FD, 32'h62A80F00, 32'hBB25BFE2, 32'h35BDD2F6,
        32'h71126905, 32'hB2040222, 32'hB6CBCF7C, 32'hCD769C2B,
        32'h53113EC0, 32'h1640E3D3, 32'h38ABBD60, 32'h2547ADF0,
        32'hBA38209C, 32'hF746CE76, 32'h77AFA1C5, 32'h20756060,
        32'h85CBFE4E, 32'h8AE88DD8, 32'h7AAAF9B0, 32'h4CF9AA7E,
        32'h1948C25C, 32'h02FB8A8C, 32'h01C36AE4, 32'hD6EBE1F9,
        32'h90D4F869, 32'hA65CDEA0, 32'h3F09252D, 32'hC208E69F,
        32'hB74E6132, 32'hCE77E25B, 32'h578FDFE3, 32'h3AC372E6
    };

endpackage

// ----- design/bf_req_if.sv -----
// Request channel: block halves, function code and key bytes.
interface bf_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [31:0] left_in;
    logic [31:0] right_in;
    logic [7:0]  key_byte;
    logic        key_last;

    modport source (output valid, func, left_in, right_in, key_byte, key_last, input ready);
    modport sink   (input valid, func, left_in, right_in, key_byte, key_last, output ready);
endinterface

// ----- design/bf_rsp_if.sv -----
// Response channel: processed block or key schedule completion.
interface bf_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] left_out;
    logic [31:0] right_out;
    logic        kind;

    modport source (output valid, left_out, right_out, kind, input ready);
    modport sink   (input valid, left_out, right_out, kind, output ready);
endinterface

// ----- design/blowfish_block_cipher.sv -----
// Blowfish engine top level: subkey registers, S-box banks, key store and sequencer.
//
// Usage. Requests arrive on req (valid/ready). func selects encrypt, decrypt or
// key byte. Key bytes are stored in order; the byte with key_last set starts the
// key schedule, which reports one transfer on rsp with kind set and zero halves.
// Encrypt and decrypt requests each give one rsp transfer with the 64-bit block.
// Unused function codes are taken and dropped.
// Timing. A block runs one Feistel round per cycle, each round reading the
// four S-box banks at once, then passes through ST_DONE to the output register;
// no new request is taken until the previous result has gone to that register.
// The key schedule runs an S-box reload sweep over all 256 entries, folds the key
// into the subkeys (one key-store read per cycle) and runs 521 encryptions,
// each of 16 rounds plus two write-back states and a relaunch.
// Reset. After rst_n the same reload sweep loads the S-box banks from the pi-digit
// tables; req.ready stays low until it ends.
// Stalls. The result sits in an output register; while rsp.ready is low the
// engine still takes the next request and computes it, then waits with that
// result until the output register frees up.
module blowfish_block_cipher #(
    parameter int MAX_KEY_BYTES = bf_pkg::DEFAULT_MAX_KEY_BYTES
) (
    input  logic      clk,
    input  logic      rst_n,
    bf_req_if.sink    req,
    bf_rsp_if.source  rsp
);

    localparam int KCW = $clog2(MAX_KEY_BYTES + 1);
    localparam int KIW = $clog2(MAX_KEY_BYTES);
    localparam int NSK = bf_pkg::NUM_SUBKEYS;
    localparam int KEY_BYTES_TOTAL = 4 * NSK;

    typedef enum logic [7:0] {
        ST_INIT   = 8'b0000_0001,
        ST_IDLE   = 8'b0000_0010,
        ST_KEY    = 8'b0000_0100,
        ST_RUN    = 8'b0000_1000,
        ST_WRL    = 8'b0001_0000,
        ST_WRR    = 8'b0010_0000,
        ST_LAUNCH = 8'b0100_0000,
        ST_DONE   = 8'b1000_0000
    } state_t;

    state_t      state_reg, state_next;
    logic [31:0] p_reg [NSK];
    logic [31:0] p_next [NSK];
    logic [31:0] x_reg, x_next;
    logic [31:0] y_reg, y_next;
    logic [31:0] l_reg, l_next;
    logic [31:0] r_reg, r_next;
    logic [31:0] w_reg, w_next;
    logic [3:0]  round_reg, round_next;
    logic        dec_reg, dec_next;
    logic        exp_reg, exp_next;
    logic        kind_reg, kind_next;
    logic [7:0]  sweep_reg, sweep_next;
    logic [6:0]  kb_reg, kb_next;
    logic [KIW-1:0] j_reg, j_next;
    logic [KCW-1:0] key_count_reg, key_count_next;
    logic [9:0]  pair_reg, pair_next;

    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_l_reg, out_l_next;
    logic [31:0] out_r_reg, out_r_next;
    logic        out_kind_reg, out_kind_next;

    // S-box bank ports
    logic [3:0]  sb_wr_en;
    logic [7:0]  sb_wr_addr;
    logic [31:0] sb_wr_data [4];
    logic [7:0]  sb_rd_addr [4];
    logic [31:0] sb_rd_data [4];

    // Key store ports
    logic           ks_wr_en;
    logic [7:0]     ks_rd_data;

    // Datapath helpers
    logic [31:0] f_val;
    logic [31:0] nb;
    logic [3:0]  r1;
    logic [4:0]  next_idx;
    logic [6:0]  bidx;
    logic [8:0]  spair;
    logic [9:0]  s_idx;
    logic [KCW-1:0] j_inc;
    logic        req_xfer;

    genvar g;
    generate
        for (g = 0; g < 4; g++)
        begin : g_bank
            bf_ram #(
                .WIDTH (32),
                .DEPTH (bf_pkg::SBOX_DEPTH)
            ) u_sbox (
                .clk     (clk),
                .wr_en   (sb_wr_en[g]),
                .wr_addr (sb_wr_addr),
                .wr_data (sb_wr_data[g]),
                .rd_addr (sb_rd_addr[g]),
                .rd_data (sb_rd_data[g])
            );
        end
    endgenerate

    bf_ram #(
        .WIDTH (8),
        .DEPTH (MAX_KEY_BYTES)
    ) u_key_store (
        .clk     (clk),
        .wr_en   (ks_wr_en),
        .wr_addr (key_count_reg[KIW-1:0]),
        .wr_data (req.key_byte),
        .rd_addr (j_reg),
        .rd_data (ks_rd_data)
    );

    assign req.ready     = (state_reg == ST_IDLE);
    assign req_xfer      = req.valid && req.ready;
    assign rsp.valid     = out_valid_reg;
    assign rsp.left_out  = out_l_reg;
    assign rsp.right_out = out_r_reg;
    assign rsp.kind      = out_kind_reg;

    // Round function on the bank outputs
    assign f_val    = ((sb_rd_data[0] + sb_rd_data[1]) ^ sb_rd_data[2]) + sb_rd_data[3];
    assign nb       = y_reg ^ f_val;
    assign r1       = round_reg + 4'd1;
    assign next_idx = dec_reg ? (5'(NSK - 1) - {1'b0, r1}) : {1'b0, r1};
    assign bidx     = kb_reg - 7'd1;
    assign spair    = 9'(pair_reg - 10'(bf_pkg::P_PAIRS));
    assign s_idx    = {spair, 1'b0};
    assign j_inc    = KCW'(j_reg) + KCW'(1);

    // Bank read addresses follow the next left half
    always_comb
    begin
        sb_rd_addr[0] = x_next[31:24];
        sb_rd_addr[1] = x_next[23:16];
        sb_rd_addr[2] = x_next[15:8];
        sb_rd_addr[3] = x_next[7:0];
    end

    // Sequencer and datapath
    always_comb
    begin
        state_next     = state_reg;
        p_next         = p_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        l_next         = l_reg;
        r_next         = r_reg;
        w_next         = w_reg;
        round_next     = round_reg;
        dec_next       = dec_reg;
        exp_next       = exp_reg;
        kind_next      = kind_reg;
        sweep_next     = sweep_reg;
        kb_next        = kb_reg;
        j_next         = j_reg;
        key_count_next = key_count_reg;
        pair_next      = pair_reg;
        sb_wr_en       = 4'b0000;
        sb_wr_addr     = sweep_reg;
        sb_wr_data[0]  = l_reg;
        sb_wr_data[1]  = l_reg;
        sb_wr_data[2]  = l_reg;
        sb_wr_data[3]  = l_reg;
        ks_wr_en       = 1'b0;

        // Output register frees on a transfer
        out_valid_next = out_valid_reg && !rsp.ready;
        out_l_next     = out_l_reg;
        out_r_next     = out_r_reg;
        out_kind_next  = out_kind_reg;

        case (state_reg)
            // Reload all four banks from the pi-digit tables
            ST_INIT:
            begin
                sb_wr_en   = 4'b1111;
                sb_wr_addr = sweep_reg;
                for (int b = 0; b < 4; b++)
                begin
                    sb_wr_data[b] = bf_pkg::SBOX_INIT[{b[1:0], sweep_reg}];
                end
                sweep_next = sweep_reg + 8'd1;
                if (sweep_reg == 8'hFF)
                begin
                    state_next = exp_reg ? ST_KEY : ST_IDLE;
                    kb_next    = '0;
                    j_next     = '0;
                    w_next     = '0;
                    l_next     = '0;
                    r_next     = '0;
                end
            end

            ST_IDLE:
            begin
                if (req_xfer)
                begin
                    case (req.func)
                        bf_pkg::FUNC_ENC, bf_pkg::FUNC_DEC:
                        begin
                            dec_next   = (req.func == bf_pkg::FUNC_DEC);
                            x_next     = req.left_in ^
                                ((req.func == bf_pkg::FUNC_DEC) ? p_reg[NSK-1] : p_reg[0]);
                            y_next     = req.right_in;
                            round_next = '0;
                            exp_next   = 1'b0;
                            state_next = ST_RUN;
                        end
                        bf_pkg::FUNC_KEY:
                        begin
                            if (key_count_reg < KCW'(MAX_KEY_BYTES))
                            begin
                                ks_wr_en       = 1'b1;
                                key_count_next = key_count_reg + KCW'(1);
                            end
                            if (req.key_last)
                            begin
                                exp_next   = 1'b1;
                                sweep_next = '0;
                                for (int i = 0; i < NSK; i++)
                                begin
                                    p_next[i] = bf_pkg::P_INIT[i];
                                end
                                state_next = ST_INIT;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            // Fold the cycled key into the subkeys, one byte per cycle
            ST_KEY:
            begin
                if (kb_reg < 7'(KEY_BYTES_TOTAL))
                begin
                    j_next  = (j_inc >= key_count_reg) ? '0 : j_reg + KIW'(1);
                    kb_next = kb_reg + 7'd1;
                end
                if (kb_reg != 7'd0)
                begin
                    w_next = {w_reg[23:0], ks_rd_data};
                    if (bidx[1:0] == 2'd3)
                    begin
                        p_next[bidx[6:2]] = p_reg[bidx[6:2]] ^ {w_reg[23:0], ks_rd_data};
                    end
                end
                if (kb_reg == 7'(KEY_BYTES_TOTAL))
                begin
                    pair_next  = '0;
                    state_next = ST_LAUNCH;
                end
            end

            // One Feistel round per cycle
            ST_RUN:
            begin
                if (round_reg != 4'(bf_pkg::ROUNDS - 1))
                begin
                    x_next     = nb ^ p_reg[next_idx];
                    y_next     = x_reg;
                    round_next = r1;
                end
                else
                begin
                    l_next = x_reg ^ (dec_reg ? p_reg[0] : p_reg[NSK-1]);
                    r_next = nb ^ (dec_reg ? p_reg[1] : p_reg[NSK-2]);
                    if (exp_reg)
                    begin
                        state_next = ST_WRL;
                    end
                    else
                    begin
                        kind_next  = bf_pkg::KIND_BLOCK;
                        state_next = ST_DONE;
                    end
                end
            end

            // Write back the left word to an S-box bank, or both subkeys for a subkey pair
            ST_WRL:
            begin
                if (pair_reg < 10'(bf_pkg::P_PAIRS))
                begin
                    p_next[{pair_reg[3:0], 1'b0}] = l_reg;
                    p_next[{pair_reg[3:0], 1'b1}] = r_reg;
                end
                else
                begin
                    sb_wr_addr             = s_idx[7:0];
                    sb_wr_data[s_idx[9:8]] = l_reg;
                    sb_wr_en[s_idx[9:8]]   = 1'b1;
                end
                state_next = ST_WRR;
            end

            // Write back the right word
            ST_WRR:
            begin
                if (pair_reg >= 10'(bf_pkg::P_PAIRS))
                begin
                    sb_wr_addr             = {s_idx[7:1], 1'b1};
                    sb_wr_data[s_idx[9:8]] = r_reg;
                    sb_wr_en[s_idx[9:8]]   = 1'b1;
                end
                if (pair_reg == 10'(bf_pkg::EXP_PAIRS - 1))
                begin
                    key_count_next = '0;
                    kind_next      = bf_pkg::KIND_DONE;
                    l_next         = '0;
                    r_next         = '0;
                    state_next     = ST_DONE;
                end
                else
                begin
                    pair_next  = pair_reg + 10'd1;
                    state_next = ST_LAUNCH;
                end
            end

            // Start the next chained encryption
            ST_LAUNCH:
            begin
                x_next     = l_reg ^ p_reg[0];
                y_next     = r_reg;
                dec_next   = 1'b0;
                round_next = '0;
                state_next = ST_RUN;
            end

            // Hand the result to the output register
            ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_l_next     = l_reg;
                    out_r_next     = r_reg;
                    out_kind_next  = kind_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            sweep_reg     <= '0;
            exp_reg       <= 1'b0;
            key_count_reg <= '0;
            out_valid_reg <= 1'b0;
            round_reg     <= '0;
            kb_reg        <= '0;
            pair_reg      <= '0;
            for (int i = 0; i < NSK; i++)
            begin
                p_reg[i] <= bf_pkg::P_INIT[i];
            end
        end
        else
        begin
            state_reg     <= state_next;
            sweep_reg     <= sweep_next;
            exp_reg       <= exp_next;
            key_count_reg <= key_count_next;
            out_valid_reg <= out_valid_next;
            round_reg     <= round_next;
            kb_reg        <= kb_next;
            pair_reg      <= pair_next;
            p_reg         <= p_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        y_reg        <= y_next;
        l_reg        <= l_next;
        r_reg        <= r_next;
        w_reg        <= w_next;
        dec_reg      <= dec_next;
        kind_reg     <= kind_next;
        j_reg        <= j_next;
        out_l_reg    <= out_l_next;
        out_r_reg    <= out_r_next;
        out_kind_reg <= out_kind_next;
    end

    // Checks
    a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("response raised without a finished item");

    a_init_exit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_INIT |=>
            (state_reg == ST_INIT || state_reg == ST_IDLE || state_reg == ST_KEY))
        else $error("reload sweep left to a wrong state");

    a_key_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        key_count_reg <= KCW'(MAX_KEY_BYTES))
        else $error("key byte count beyond the key store");

    a_done_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && kind_reg == bf_pkg::KIND_DONE) |->
            (key_count_reg == '0 && exp_reg))
        else $error("schedule completion without a finished expansion");

endmodule

// ----- design/bf_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module bf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port; old data on a same-address write
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule
